[hw/rtl/mac_ip_binding_access_check_macros.svh]
// Assertion macros used by the binding access check checker.
`ifndef MAC_IP_BINDING_ACCESS_CHECK_MACROS_SVH
`define MAC_IP_BINDING_ACCESS_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MIBAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MIBAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mibac_pkg.sv]
// Types, codes and defaults for the MAC/IP binding access check.
package mibac_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned USER_SLOTS_DEF    = 16;
  localparam int unsigned USER_ID_VALUES    = 16;

  localparam logic [7:0] MAX_CONN_RESET = 8'd5;

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_VALIDATE   = 2'd1;
  localparam logic [1:0] CMD_DISCONNECT = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_LIMIT    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic REG_MAX_CONN = 1'b0;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] mac;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic        ip_is_v6;
    logic [3:0]  user_id;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] status;
    logic [7:0] user_count;
  } rsp_t;

endpackage

[hw/rtl/mac_ip_binding_access_check.sv]
// Top level of the MAC/IP binding access check.
//
// Request channel (req_valid, req_stall, req) carries one command word:
// register a device, validate an access, or disconnect a device.
// Response channel (rsp_valid, rsp_stall, rsp) returns one word per
// request: granted flag, status code and the user's connection count.
// A word is taken at a rising edge with valid high and stall low.
// An accepted request is held in the request register, which feeds a
// parallel MAC match over all table entries; the response register and
// table update load when the request advances.
// Throughput is one request per cycle while rsp_stall does not hold a
// response; the table and count update of one request are written as it
// leaves the request register, so the next request sees them at once.
// Reset (rst, synchronous) clears entry valid bits, all connection counts
// and both stage valids, and loads max_connections with 5.
// While rsp_stall holds a waiting response, the request register holds and
// req_stall rises once it is full; no table change happens meanwhile.
// max_connections is written through the APB port at byte address 0; the
// user must write it only while no request is in flight; the block itself does not enforce this.
module mac_ip_binding_access_check
  import mibac_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned USER_SLOTS    = USER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SLOT_W  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

  logic [7:0] max_conn;

  logic        entry_valid    [TABLE_ENTRIES];
  logic [47:0] entry_mac      [TABLE_ENTRIES];
  logic [63:0] entry_ip_upper [TABLE_ENTRIES];
  logic [63:0] entry_ip_lower [TABLE_ENTRIES];
  logic        entry_ipv6     [TABLE_ENTRIES];
  logic [3:0]  entry_owner    [TABLE_ENTRIES];
  logic [7:0]  conn_count     [USER_SLOTS];

  logic [SLOT_W-1:0] slot_lut [USER_ID_VALUES];

  req_t cur_req;
  logic cur_valid;
  logic advance;

  logic [63:0]        ip_hi;
  logic [63:0]        ip_lo;
  logic               hit_any;
  logic               free_any;
  logic [ENTRY_W-1:0] hit_idx;
  logic [ENTRY_W-1:0] free_idx;
  logic [3:0]         owner;
  logic               ip_match;
  logic [SLOT_W-1:0]  slot;
  logic [7:0]         cur_count;

  logic               ent_we;
  logic [ENTRY_W-1:0] ent_sel;
  logic               cnt_we;
  logic [7:0]         cnt_new;
  rsp_t               result;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_conn <= MAX_CONN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CONN) begin
      max_conn <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_CONN) begin
      prdata = {24'd0, max_conn};
    end
  end

  // User number to count slot
  for (genvar g = 0; g < USER_ID_VALUES; g++) begin : g_slot
    localparam int unsigned SLOT_VAL = g % USER_SLOTS;
    assign slot_lut[g] = SLOT_W'(SLOT_VAL);
  end

  // Handshake
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = cur_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      cur_valid <= 1'b1;
    end else if (advance) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cur_req <= req;
    end
  end

  // Lookup
  always_comb begin
    ip_hi    = cur_req.ip_is_v6 ? cur_req.ip_high : 64'd0;
    ip_lo    = cur_req.ip_is_v6 ? cur_req.ip_low : {32'd0, cur_req.ip_low[31:0]};
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_mac[i] == cur_req.mac) begin
        hit_any = 1'b1;
        hit_idx = ENTRY_W'(i);
      end
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = ENTRY_W'(i);
      end
    end
  end

  assign owner    = entry_owner[hit_idx];
  assign ip_match = entry_ipv6[hit_idx] == cur_req.ip_is_v6 &&
                    entry_ip_upper[hit_idx] == ip_hi &&
                    entry_ip_lower[hit_idx] == ip_lo;
  assign slot      = (cur_req.cmd == CMD_REGISTER) ? slot_lut[cur_req.user_id] : slot_lut[owner];
  assign cur_count = conn_count[slot];

  // Decide
  always_comb begin
    ent_we            = 1'b0;
    ent_sel           = hit_any ? hit_idx : free_idx;
    cnt_we            = 1'b0;
    cnt_new           = cur_count;
    result.granted    = 1'b0;
    result.status     = ST_OK;
    result.user_count = 8'd0;
    unique case (cur_req.cmd)
      CMD_REGISTER: begin
        result.user_count = cur_count;
        if (hit_any || free_any) begin
          ent_we         = 1'b1;
          result.granted = 1'b1;
        end else begin
          result.status = ST_FULL;
        end
      end
      CMD_VALIDATE: begin
        if (!hit_any) begin
          result.status = ST_UNKNOWN;
        end else if (!ip_match) begin
          result.status     = ST_MISMATCH;
          result.user_count = cur_count;
        end else if (cur_count >= max_conn) begin
          result.status     = ST_LIMIT;
          result.user_count = cur_count;
        end else begin
          cnt_we            = 1'b1;
          cnt_new           = (cur_count == COUNT_MAX) ? cur_count : cur_count + 8'd1;
          result.granted    = 1'b1;
          result.user_count = cnt_new;
        end
      end
      CMD_DISCONNECT: begin
        if (!hit_any) begin
          result.status = ST_UNKNOWN;
        end else begin
          cnt_we            = 1'b1;
          cnt_new           = (cur_count == 8'd0) ? cur_count : cur_count - 8'd1;
          result.granted    = 1'b1;
          result.user_count = cnt_new;
        end
      end
      default: begin
      end
    endcase
  end

  // Table and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (cur_valid && advance && ent_we) begin
      entry_valid[ent_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_valid && advance && ent_we) begin
      entry_mac[ent_sel]      <= cur_req.mac;
      entry_ip_upper[ent_sel] <= ip_hi;
      entry_ip_lower[ent_sel] <= ip_lo;
      entry_ipv6[ent_sel]     <= cur_req.ip_is_v6;
      entry_owner[ent_sel]    <= cur_req.user_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USER_SLOTS; i++) begin
        conn_count[i] <= 8'd0;
      end
    end else if (cur_valid && advance && cnt_we) begin
      conn_count[slot] <= cnt_new;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cur_valid) begin
      rsp <= result;
    end
  end

endmodule

[hw/rtl/mibac_check.sv]
// Port-level checker for the MAC/IP binding access check, with its bind.
`include "mac_ip_binding_access_check_macros.svh"

module mibac_check
  import mibac_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `MIBAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response word changed")
  `MIBAC_ASSERT_NOW(a_grant_ok, rsp_valid && rsp.granted, rsp.status == ST_OK, "grant with failing status")
  `MIBAC_ASSERT_NOW(a_unknown_zero, rsp_valid && rsp.status == ST_UNKNOWN, !rsp.granted && rsp.user_count == 8'd0, "unknown MAC reports a count")
  `MIBAC_ASSERT_NOW(a_status_range, rsp_valid, rsp.status == ST_OK || rsp.status == ST_UNKNOWN || rsp.status == ST_MISMATCH || rsp.status == ST_LIMIT || rsp.status == ST_FULL, "status code out of range")

endmodule

bind mac_ip_binding_access_check mibac_check u_check (.*);
